@@ design/jet_pkg.sv @@
`timescale 1ns / 1ps

package jet_pkg;

    // parameter defaults
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 28;

    // field widths fixed by the interface
    localparam int PIX_W   = 12;
    localparam int COUNT_W = 16;
    localparam int ADDR_W  = 5;

    // register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_STEP_X   = 3'd2,
        REG_STEP_Y   = 3'd3,
        REG_C_REAL   = 3'd4,
        REG_C_IMAG   = 3'd5,
        REG_MAX_ITER = 3'd6
    } reg_idx_t;

    // register reset values
    localparam logic signed [31:0] ORIGIN_X_RST = -32'sd402653184;
    localparam logic signed [31:0] ORIGIN_Y_RST = 32'sd402653184;
    localparam logic [30:0]        STEP_X_RST   = 31'd786432;
    localparam logic [30:0]        STEP_Y_RST   = 31'd786432;
    localparam logic signed [31:0] C_REAL_RST   = -32'sd214748365;
    localparam logic signed [31:0] C_IMAG_RST   = 32'sd41875931;
    localparam logic [15:0]        MAX_ITER_RST = 16'd256;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_col;
        logic [PIX_W-1:0] pixel_row;
    } pix_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] iteration_count;
        logic               inside_set;
    } pix_out_t;

    // clamp a 64-bit value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ design/julia_escape_time_top.sv @@
`timescale 1ns / 1ps

// julia set escape-time evaluator, one pixel at a time
// input channel (s_valid/s_ready/s_data): one transfer carries a pixel column
// and row; the low COORD_BITS bits of each are used
// result channel (m_valid/m_ready/m_data): one transfer per pixel with the
// iteration count and the in-set flag
// config: apb-style write/read port, register i at byte address 4*i, pready
// tied high; write registers only while no pixel is in flight
// datapath: one signed 33x33 multiplier with a registered product is shared
// by every multiply; the start point is formed in S_MX, S_MY and S_INIT, each
// z = z^2 + c iteration steps through S_I1 to S_I5 (zr^2, zi^2, zr*zi, nr^2,
// ni^2 through the one multiplier), and the result is handed off in S_DONE
// s_ready is high only while the sequencer is idle
// the result sits in an output register; a new pixel is taken while it waits,
// and a finished pixel holds in the done state until that register frees up
// reset (aresetn low, synchronous) returns the config registers to their
// defaults, empties the output register and idles the sequencer
module julia_escape_time_top #(
    parameter int COORD_BITS = jet_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = jet_pkg::FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // pixel input
    input  logic                      s_valid,
    output logic                      s_ready,
    input  jet_pkg::pix_in_t          s_data,
    // result output
    output logic                      m_valid,
    input  logic                      m_ready,
    output jet_pkg::pix_out_t         m_data,
    // config port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [jet_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import jet_pkg::*;

    // mask keeps only the low COORD_BITS bits of a coordinate
    localparam logic [PIX_W-1:0] COORD_MASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);
    // escape threshold 4.0
    localparam logic signed [63:0] ESC_LIMIT = 64'sd4 <<< FRAC_BITS;

    // sequencer states
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MX   = 10'b00_0000_0010,
        S_MY   = 10'b00_0000_0100,
        S_INIT = 10'b00_0000_1000,
        S_I1   = 10'b00_0001_0000,
        S_I2   = 10'b00_0010_0000,
        S_I3   = 10'b00_0100_0000,
        S_I4   = 10'b00_1000_0000,
        S_I5   = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic signed [31:0] origin_x_reg, origin_y_reg, c_real_reg, c_imag_reg;
    logic [30:0]        step_x_reg, step_y_reg;
    logic [15:0]        max_iter_reg;
    logic [2:0]         reg_idx;
    logic               cfg_wr;

    // datapath
    pix_in_t            pix_reg;
    logic signed [31:0] zr_reg, zi_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_inc;

    logic signed [63:0] prod_sh;     // product rescaled by FRAC_BITS
    logic signed [63:0] prod_sh2;    // doubled cross term
    logic signed [63:0] norm;
    logic               out_free;

    // output register
    logic               m_valid_reg;
    pix_out_t           m_data_reg;

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= ORIGIN_X_RST;
            origin_y_reg <= ORIGIN_Y_RST;
            step_x_reg   <= STEP_X_RST;
            step_y_reg   <= STEP_Y_RST;
            c_real_reg   <= C_REAL_RST;
            c_imag_reg   <= C_IMAG_RST;
            max_iter_reg <= MAX_ITER_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ORIGIN_X: origin_x_reg <= pwdata;
                REG_ORIGIN_Y: origin_y_reg <= pwdata;
                REG_STEP_X:   step_x_reg   <= pwdata[30:0];
                REG_STEP_Y:   step_y_reg   <= pwdata[30:0];
                REG_C_REAL:   c_real_reg   <= pwdata;
                REG_C_IMAG:   c_imag_reg   <= pwdata;
                REG_MAX_ITER: max_iter_reg <= pwdata[15:0];
                default: ;   // unmapped address, write dropped
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_ORIGIN_X: prdata = origin_x_reg;
            REG_ORIGIN_Y: prdata = origin_y_reg;
            REG_STEP_X:   prdata = {1'b0, step_x_reg};
            REG_STEP_Y:   prdata = {1'b0, step_y_reg};
            REG_C_REAL:   prdata = c_real_reg;
            REG_C_IMAG:   prdata = c_imag_reg;
            REG_MAX_ITER: prdata = {16'd0, max_iter_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------- shared multiplier ----------------
    // operand select per step; the product is registered and used next cycle
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MX: begin
                // col * step_x, both unsigned
                mul_a = $signed({21'd0, pix_reg.pixel_col & COORD_MASK});
                mul_b = $signed({2'd0, step_x_reg});
            end
            S_MY: begin
                mul_a = $signed({21'd0, pix_reg.pixel_row & COORD_MASK});
                mul_b = $signed({2'd0, step_y_reg});
            end
            S_INIT, S_I3, S_I5: begin
                // zr^2 (S_I3: zr already holds the new real part)
                mul_a = 33'(zr_reg);
                mul_b = 33'(zr_reg);
            end
            S_I1, S_I4: begin
                mul_a = 33'(zi_reg);
                mul_b = 33'(zi_reg);
            end
            S_I2: begin
                mul_a = 33'(zr_reg);
                mul_b = 33'(zi_reg);
            end
            default: ;
        endcase
    end

    assign mul_full = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_full[63:0];
    end

    assign prod_sh  = prod_reg >>> FRAC_BITS;
    assign prod_sh2 = prod_reg >>> (FRAC_BITS - 1);
    assign norm     = acc_reg + prod_sh;
    assign count_inc = count_reg + 1'b1;
    assign out_free = ~m_valid_reg | m_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_MX;
            S_MX:   state_next = S_MY;
            S_MY:   state_next = S_INIT;
            S_INIT: begin
                // a limit of 0 or 1 runs no iteration
                if (max_iter_reg <= 16'd1) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_I1;
                end
            end
            S_I1:   state_next = S_I2;
            S_I2:   state_next = S_I3;
            S_I3:   state_next = S_I4;
            S_I4:   state_next = S_I5;
            S_I5: begin
                // escape freezes the count; otherwise stop once the limit is hit
                if (norm > ESC_LIMIT || count_inc >= max_iter_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_I1;
                end
            end
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: if (s_valid) pix_reg <= s_data;
            S_MY:   zr_reg <= sat32(64'(origin_x_reg) + prod_reg);
            S_INIT: begin
                zi_reg    <= sat32(64'(origin_y_reg) - prod_reg);
                count_reg <= COUNT_W'(1);
            end
            S_I1:   acc_reg <= prod_sh;                    // zr^2
            S_I2:   zr_reg  <= sat32(acc_reg - prod_sh + 64'(c_real_reg));
            S_I3:   zi_reg  <= sat32(prod_sh2 + 64'(c_imag_reg));
            S_I4:   acc_reg <= prod_sh;                    // new zr^2
            S_I5:   if (!(norm > ESC_LIMIT)) count_reg <= count_inc;
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_data_reg.iteration_count <= count_reg;
            m_data_reg.inside_set      <= (count_reg >= max_iter_reg);
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
